@@ sv/pcxrle_pkg.sv @@
// Package: types, constants and register codes for the PCX RLE planar decoder.
`timescale 1ns / 1ps

package pcxrle_pkg;

    localparam int DEF_MAX_LINE_BYTES = 2048;
    localparam int PLANES             = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 17;
    localparam int STRIDE_W   = 12;
    localparam int RUN_W      = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_LINE_BYTES = 2'd2;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH      = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT     = 17'd480;
    localparam logic [STRIDE_W-1:0] RST_PLANE_LINE_BYTES = 12'd640;

    localparam logic [7:0]       RUN_MARK = 8'hC0;
    localparam logic [RUN_W-1:0] RUN_MASK = 6'h3F;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_item;
        logic       end_of_row;
        logic       end_of_image;
        logic       run_clipped;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_pcxrle_cmd;

    // datapath -> controller
    typedef struct packed {
        logic work;
        logic step_ok;
        logic step_end;
    } t_pcxrle_stat;

endpackage

@@ sv/pcxrle_ctrl.sv @@
// Controller: accepts bytes and sequences the decode steps of each byte.
`timescale 1ns / 1ps

module pcxrle_ctrl
    import pcxrle_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  t_pcxrle_stat i_stat,
    output t_pcxrle_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_STEP = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_stat.work) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step = i_stat.step_ok;
                if (i_stat.step_ok && i_stat.step_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/pcxrle_datapath.sv @@
// Datapath: position counters, plane line store, pixel stage and output register.
`timescale 1ns / 1ps

module pcxrle_datapath
    import pcxrle_pkg::*;
#(
    parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [WIDTH_W-1:0]  i_image_width,
    input  logic [HEIGHT_W-1:0] i_image_height,
    input  logic [STRIDE_W-1:0] i_plane_line_bytes,
    input  t_in_item            i_in_item,
    input  t_pcxrle_cmd         i_cmd,
    output t_pcxrle_stat        o_stat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item
);

    localparam int STRIDE_MAX = (MAX_LINE_BYTES < 4095) ? MAX_LINE_BYTES : 4095;
    localparam int POS_W      = $clog2(PLANES * STRIDE_MAX + 1);
    localparam int ADDR_W     = $clog2(STRIDE_MAX);
    localparam logic [STRIDE_W-1:0] STRIDE_CAP = STRIDE_W'(STRIDE_MAX);

    // line store, planes 0 and 1
    logic [7:0] r_plane0 [STRIDE_MAX];
    logic [7:0] r_plane1 [STRIDE_MAX];
    logic [7:0] r_rd0;
    logic [7:0] r_rd1;

    // decode state
    logic [POS_W-1:0]    r_lp;
    logic [HEIGHT_W-1:0] r_row;
    logic                r_done;
    logic                r_pending;
    logic [RUN_W-1:0]    r_count;
    logic [RUN_W-1:0]    r_k;
    logic                r_clip;
    logic [7:0]          r_byte;

    // pixel stage (waits for store read data)
    logic       r_s1_valid;
    logic [7:0] r_s1_red;
    logic       r_s1_last;
    logic       r_s1_eor;
    logic       r_s1_eoi;
    logic       r_s1_clip;

    logic      r_out_valid;
    t_out_item r_out_item;

    // derived geometry
    logic [STRIDE_W-1:0] stride;
    logic [POS_W-1:0]    s_pos;
    logic [POS_W-1:0]    s2_pos;
    logic [POS_W-1:0]    len;
    logic [POS_W-1:0]    w_pos;

    always_comb begin
        if (i_plane_line_bytes == '0) begin
            stride = STRIDE_W'(1);
        end else if (i_plane_line_bytes > STRIDE_CAP) begin
            stride = STRIDE_CAP;
        end else begin
            stride = i_plane_line_bytes;
        end
        s_pos  = POS_W'(stride);
        s2_pos = POS_W'({stride, 1'b0});
        len    = s2_pos + s_pos;
        w_pos  = (i_image_width < stride) ? POS_W'(i_image_width) : s_pos;
    end

    // load decisions
    logic             ld_closed;
    logic             ld_pending;
    logic [POS_W-1:0] ld_pos;
    logic             ld_header;
    logic [POS_W:0]   ld_run_end;

    always_comb begin
        ld_pending = i_in_item.restart ? 1'b0 : r_pending;
        ld_closed  = i_in_item.restart ? (i_image_height == '0)
                                       : (r_done || (r_row >= i_image_height));
        ld_pos     = (i_in_item.restart || (r_lp >= len)) ? '0 : r_lp;
        ld_header  = ((i_in_item.code_byte & RUN_MARK) == RUN_MARK);
        ld_run_end = {1'b0, ld_pos} + (POS_W + 1)'(r_count);
    end

    // step decisions
    logic                wrap;
    logic [HEIGHT_W:0]   row_a;
    logic [HEIGHT_W:0]   row_b;
    logic                wrap_close;
    logic [POS_W-1:0]    p;
    logic [POS_W-1:0]    p1;
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    col1;
    logic                in_p0;
    logic                in_p1;
    logic                emit;
    logic                eol;
    logic                k_last;
    logic [POS_W-1:0]    p_sub;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   col_addr;
    logic                s1_move;

    always_comb begin
        wrap       = (r_lp >= len);
        row_a      = {1'b0, r_row} + (HEIGHT_W + 1)'(wrap);
        row_b      = row_a + (HEIGHT_W + 1)'(1);
        wrap_close = wrap && (row_a >= {1'b0, i_image_height});
        p          = wrap ? '0 : r_lp;
        p1         = p + POS_W'(1);
        eol        = (p1 >= len);
        in_p0      = (p < s_pos);
        in_p1      = !in_p0 && (p < s2_pos);
        col        = p - s2_pos;
        col1       = col + POS_W'(1);
        emit       = !wrap_close && !in_p0 && !in_p1 && (col < w_pos);
        k_last     = (r_k == RUN_W'(1));
        p_sub      = in_p0 ? p : (p - s_pos);
        wr_addr    = p_sub[ADDR_W-1:0];
        col_addr   = col[ADDR_W-1:0];
    end

    assign s1_move = r_s1_valid && (!r_out_valid || !i_out_stall);

    assign o_stat.work     = !ld_closed &&
                             (ld_pending ? (r_count != '0) : !ld_header);
    assign o_stat.step_ok  = !r_s1_valid || s1_move;
    assign o_stat.step_end = wrap_close || eol || k_last;

    // line store
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && !wrap_close) begin
            if (in_p0) begin
                r_plane0[wr_addr] <= r_byte;
            end
            if (in_p1) begin
                r_plane1[wr_addr] <= r_byte;
            end
        end
        if (i_cmd.step && emit) begin
            r_rd0 <= r_plane0[col_addr];
            r_rd1 <= r_plane1[col_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp        <= '0;
            r_row       <= '0;
            r_done      <= 1'b0;
            r_pending   <= 1'b0;
            r_count     <= '0;
            r_k         <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_in_item.restart) begin
                    r_lp   <= '0;
                    r_row  <= '0;
                    r_done <= 1'b0;
                end
                if (!ld_closed && ld_pending) begin
                    r_pending <= 1'b0;
                    r_count   <= '0;
                    r_k       <= r_count;
                end else if (!ld_closed && ld_header) begin
                    r_pending <= 1'b1;
                    r_count   <= i_in_item.code_byte[RUN_W-1:0] & RUN_MASK;
                end else if (i_in_item.restart) begin
                    r_pending <= 1'b0;
                    r_count   <= '0;
                end
                if (!ld_closed && !ld_pending && !ld_header) begin
                    r_k <= RUN_W'(1);
                end
            end
            if (i_cmd.step) begin
                r_k <= r_k - RUN_W'(1);
                if (wrap_close) begin
                    r_lp   <= '0;
                    r_row  <= row_a[HEIGHT_W-1:0];
                    r_done <= 1'b1;
                end else if (eol) begin
                    r_lp   <= '0;
                    r_row  <= row_b[HEIGHT_W-1:0];
                    r_done <= (row_b >= {1'b0, i_image_height});
                end else begin
                    r_lp  <= p1;
                    r_row <= row_a[HEIGHT_W-1:0];
                end
            end
            if (i_cmd.step && emit) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_in_item.code_byte;
            r_clip <= ld_pending && (ld_run_end > {1'b0, len});
        end
        if (i_cmd.step && emit) begin
            r_s1_red  <= r_byte;
            r_s1_last <= k_last || (col1 >= w_pos);
            r_s1_eor  <= (col1 == w_pos);
            r_s1_eoi  <= (col1 == w_pos) && (row_b >= {1'b0, i_image_height});
            r_s1_clip <= r_clip;
        end
        if (s1_move) begin
            r_out_item.red          <= r_s1_red;
            r_out_item.green        <= r_rd1;
            r_out_item.blue         <= r_rd0;
            r_out_item.last_of_item <= r_s1_last;
            r_out_item.end_of_row   <= r_s1_eor;
            r_out_item.end_of_image <= r_s1_eoi;
            r_out_item.run_clipped  <= r_s1_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ sv/pcx_rle_planar_to_rgb_decoder_unit.sv @@
// Top level: PCX 24-bit planar RLE decoder with configuration registers.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one compressed
//   byte per transfer, starting after the file header. Set restart on the
//   first byte of each image to clear the row and position counters.
//   Output channel (o_out_valid / i_out_stall / o_out_item) carries one RGB
//   pixel per transfer with row, image and run markers.
//   Config channel (i_cfg_valid / o_cfg_ready) writes width, height and
//   plane stride; write only while the decoder is idle.
// Decode steps:
//   After a byte transfer, a literal spends one decode step, a run header
//   needs no step, and a run data byte spends one step per repeated byte,
//   up to the row end. The controller issues one decode step per cycle
//   while the pixel stage can move; the input stalls until the steps end.
//   Each pixel passes the byte register, the pixel stage and the output register.
// Reset: counters clear, registers return to 640 x 480, stride 640; the line
//   store is not cleared. A stalled output holds its pixel while the decoder
//   keeps running until its pixel stage is also full, then steps pause.
`timescale 1ns / 1ps

module pcx_rle_planar_to_rgb_decoder_unit
    import pcxrle_pkg::*;
#(
    parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // compressed byte channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    // pixel channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic [STRIDE_W-1:0] r_plane_line_bytes;

    t_pcxrle_cmd  cmd;
    t_pcxrle_stat stat;

    // Config writes always complete; indexes past the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width      <= RST_IMAGE_WIDTH;
            r_image_height     <= RST_IMAGE_HEIGHT;
            r_plane_line_bytes <= RST_PLANE_LINE_BYTES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:      r_image_width      <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:     r_image_height     <= i_cfg_data[HEIGHT_W-1:0];
                CFG_PLANE_LINE_BYTES: r_plane_line_bytes <= i_cfg_data[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: one transfer in, then the byte's decode steps.
    pcxrle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Counters, line store and the two-stage pixel output.
    pcxrle_datapath #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_image_width      (r_image_width),
        .i_image_height     (r_image_height),
        .i_plane_line_bytes (r_plane_line_bytes),
        .i_in_item          (i_in_item),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_item         (o_out_item)
    );

endmodule

@@ tb/sv/pcx_rle_planar_to_rgb_decoder_unit_tb.sv @@
// Testbench for the PCX RLE planar decoder: scripted bytes, then random images checked on the fly.
`timescale 1ns / 1ps

module pcx_rle_planar_to_rgb_decoder_unit_tb;
    import pcxrle_pkg::*;

    localparam int MAX_LINE = DEF_MAX_LINE_BYTES;

    // How a scripted byte is checked: by the local decoder, against a value typed here, or as giving no pixel.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_PIXEL
    } t_chk;

    // One row of the scripted part: either a geometry reload or one byte transfer.
    typedef struct packed {
        logic         geom;
        logic [11:0]  w;
        logic [16:0]  h;
        logic [11:0]  s;
        t_in_item     item;
        t_chk         chk;
        t_out_item    px;
    } t_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pcx_rle_planar_to_rgb_decoder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Local decoder state: a copy of the line store, scan position and
    // the geometry registers as last written over the config channel.
    // ------------------------------------------------------------------
    logic [7:0]  plane_mem [0:2*MAX_LINE-1];
    int unsigned line_pos;
    int unsigned rows_done;
    int unsigned run_len;
    bit          run_armed;
    bit          frame_done;
    int unsigned geo_w;
    int unsigned geo_h;
    int unsigned geo_s;

    t_out_item   step_px[$];      // pixels of the byte being decoded
    t_out_item   pending_px[$];   // pixels still owed by the block
    int unsigned bytes_used;      // bytes that were not ignored
    int unsigned fails;

    // Shared between the stimulus and the checker or the pixel side.
    t_chk        cur_chk;
    t_out_item   cur_px;
    bit          idle_on;

    t_step       script[$];

    // ------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------

    // Stride 0 acts as 1; anything above the store depth saturates.
    function automatic int unsigned eff_stride();
        int unsigned s;
        s = geo_s;
        if (s == 0) s = 1;
        if (s > MAX_LINE) s = MAX_LINE;
        return s;
    endfunction

    // Height 0 closes the stream at once.
    function automatic bit frame_closed();
        return frame_done || rows_done >= geo_h;
    endfunction

    function automatic void close_row();
        line_pos = 0;
        rows_done++;
        if (rows_done >= geo_h) frame_done = 1'b1;
    endfunction

    // Writes one decoded byte into the scanline; returns 1 when a row closed.
    function automatic bit place_byte(input logic [7:0] v, input bit clipped);
        int unsigned s;
        int unsigned len;
        int unsigned w;
        int unsigned pos;
        int unsigned col;
        t_out_item   px;
        s   = eff_stride();
        len = s * PLANES;
        w   = (geo_w < s) ? geo_w : s;
        // position already past a (shrunk) scanline: row counts as complete
        if (line_pos >= len) begin
            close_row();
            if (frame_closed()) return 1'b1;
        end
        pos = line_pos;
        if (pos < s) begin
            plane_mem[pos] = v;
        end else if (pos < 2 * s) begin
            plane_mem[MAX_LINE + pos - s] = v;
        end else begin
            col = pos - 2 * s;
            if (col < w) begin
                px.red          = v;
                px.green        = plane_mem[MAX_LINE + col];
                px.blue         = plane_mem[col];
                px.last_of_item = 1'b0;
                px.end_of_row   = (col + 1 == w);
                px.end_of_image = px.end_of_row && (rows_done + 1 >= geo_h);
                px.run_clipped  = clipped;
                step_px.push_back(px);
            end
        end
        line_pos = pos + 1;
        if (line_pos >= len) begin
            close_row();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Decodes one accepted byte; leaves its pixels in step_px.
    function automatic void decode_byte(input t_in_item it);
        int unsigned k;
        int unsigned len;
        int unsigned start;
        bit          clipped;
        bit          stop;
        t_out_item   px;
        step_px.delete();
        if (it.restart) begin
            line_pos   = 0;
            rows_done  = 0;
            run_armed  = 1'b0;
            run_len    = 0;
            frame_done = 1'b0;
        end
        if (frame_closed()) return;
        bytes_used++;
        if (run_armed) begin
            k       = run_len;
            len     = eff_stride() * PLANES;
            start   = (line_pos >= len) ? 0 : line_pos;
            clipped = (start + k > len);
            run_armed = 1'b0;
            run_len   = 0;
            stop      = 1'b0;
            // runs end at the row boundary, the remainder is dropped
            while (k > 0 && !stop) begin
                stop = place_byte(it.code_byte, clipped);
                k--;
                if (frame_closed()) stop = 1'b1;
            end
        end else if ((it.code_byte & RUN_MARK) == RUN_MARK) begin
            run_armed = 1'b1;
            run_len   = it.code_byte[RUN_W-1:0];
        end else begin
            stop = place_byte(it.code_byte, 1'b0);
        end
        if (step_px.size() > 0) begin
            px = step_px.pop_back();
            px.last_of_item = 1'b1;
            step_px.push_back(px);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(5_000_000);
        $display("** pcx_rle_planar_to_rgb_decoder_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Checker: all transfers are observed here, in one process, so the
    // order of decode and compare is fixed.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %02h, actual %02h",
                     $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : px_check
        t_out_item want;
        if (i_rst_n) begin
            // config transfer updates the local geometry
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:      geo_w = i_cfg_data[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT:     geo_h = i_cfg_data[HEIGHT_W-1:0];
                    CFG_PLANE_LINE_BYTES: geo_s = i_cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end
            // byte transfer: decoded first, ahead of the pixel check below
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_in_item);
                if (cur_chk == CHK_MODEL)
                    foreach (step_px[j]) pending_px.push_back(step_px[j]);
                else if (cur_chk == CHK_PIXEL)
                    pending_px.push_back(cur_px);
            end
            // pixel transfer
            if (o_out_valid && !i_out_stall) begin
                if (pending_px.size() == 0) begin
                    $display("%0t ns: pixel mismatch, expected none, actual %h",
                             $time, o_out_item);
                    fails++;
                end else begin
                    want = pending_px.pop_front();
                    check_field("red",          want.red,          o_out_item.red);
                    check_field("green",        want.green,        o_out_item.green);
                    check_field("blue",         want.blue,         o_out_item.blue);
                    check_field("last_of_item", want.last_of_item, o_out_item.last_of_item);
                    check_field("end_of_row",   want.end_of_row,   o_out_item.end_of_row);
                    check_field("end_of_image", want.end_of_image, o_out_item.end_of_image);
                    check_field("run_clipped",  want.run_clipped,  o_out_item.run_clipped);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel side: before each pixel, stall is held at random while idle_on is set.
    // ------------------------------------------------------------------
    initial begin : out_side
        int hold;
        i_out_stall = 1'b0;
        forever begin
            hold = idle_on ? $urandom_range(0, 3) : 0;
            if (hold > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // ------------------------------------------------------------------
    // Byte and config drivers; all called and returning at a falling edge.
    // ------------------------------------------------------------------
    task automatic push_byte(input t_in_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Valid stays high across the three writes, dropped after the last.
    task automatic load_geometry(input int unsigned w, input int unsigned h,
                                 input int unsigned s);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_PLANE_LINE_BYTES, s);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for the owed pixels, then give pixel-less bytes (plane 0/1
    // fills, zero runs) time to finish before registers move.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_px.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    function automatic void add_geom(input int unsigned w, input int unsigned h,
                                     input int unsigned s);
        t_step st;
        st      = '0;
        st.geom = 1'b1;
        st.w    = 12'(w);
        st.h    = 17'(h);
        st.s    = 12'(s);
        script.push_back(st);
    endfunction

    function automatic void add_byte(input bit rst, input logic [7:0] b, input t_chk chk,
                                     input t_out_item px);
        t_step st;
        st                = '0;
        st.item.restart   = rst;
        st.item.code_byte = b;
        st.chk            = chk;
        st.px             = px;
        script.push_back(st);
    endfunction

    // Single pixel of a byte, so last_of_item is always set.
    function automatic t_out_item one_px(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input bit eoi, input bit clip);
        t_out_item px;
        px.red          = r;
        px.green        = g;
        px.blue         = b;
        px.last_of_item = 1'b1;
        px.end_of_row   = 1'b1;
        px.end_of_image = eoi;
        px.run_clipped  = clip;
        return px;
    endfunction

    // One image with random content. Mostly literals and runs sized to
    // fit the row, with oversized runs and stray restarts as noise.
    // long_runs feeds 63-byte runs to cover wide scanlines quickly.
    task automatic random_image(input bit long_runs, input int max_items);
        t_in_item    it;
        int          sent;
        int          r;
        int unsigned len;
        int unsigned room;
        sent    = 0;
        cur_chk = CHK_MODEL;
        while (sent < max_items && !(sent > 0 && frame_closed())) begin
            it.restart = (sent == 0);
            r    = $urandom_range(0, 19);
            len  = eff_stride() * PLANES;
            room = (line_pos < len) ? len - line_pos : len;
            if (room > 63) room = 63;
            if (run_armed) begin
                it.code_byte = 8'($urandom_range(0, 255));
            end else if (long_runs) begin
                it.code_byte = (r < 2) ? 8'($urandom_range(0, 191)) : (RUN_MARK | RUN_MASK);
            end else if (r == 0) begin
                it.restart   = 1'b1;
                it.code_byte = 8'($urandom_range(0, 255));
            end else if (r < 10) begin
                it.code_byte = RUN_MARK | 8'($urandom_range(0, 1) ? $urandom_range(0, room)
                                                                  : $urandom_range(0, 63));
            end else begin
                it.code_byte = 8'($urandom_range(0, 191));
            end
            push_byte(it);
            sent++;
        end
        // trailing bytes after the last row are dropped by the block
        if (frame_closed() && $urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 2)) begin
                it.restart   = 1'b0;
                it.code_byte = 8'($urandom_range(0, 255));
                push_byte(it);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stim
        int unsigned target;
        int unsigned w;
        int unsigned h;
        int unsigned s;
        int          r;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_IMAGE_WIDTH;
        i_cfg_data  = '0;
        line_pos    = 0;
        rows_done   = 0;
        run_len     = 0;
        run_armed   = 1'b0;
        frame_done  = 1'b0;
        geo_w       = RST_IMAGE_WIDTH;
        geo_h       = RST_IMAGE_HEIGHT;
        geo_s       = RST_PLANE_LINE_BYTES;
        bytes_used  = 0;
        fails       = 0;
        cur_chk     = CHK_MODEL;
        cur_px      = '0;
        idle_on     = 1'b1;

        // reset geometry, plane 0 only: no pixels
        add_byte(1'b1, 8'h00, CHK_NONE, '0);
        add_byte(1'b0, 8'hC0, CHK_NONE, '0);   // zero-length run header
        add_byte(1'b0, 8'hFF, CHK_NONE, '0);   // its data byte writes nothing
        // 1x1 image, stride 1
        add_geom(1, 1, 1);
        add_byte(1'b1, 8'h11, CHK_NONE, '0);
        add_byte(1'b0, 8'h22, CHK_NONE, '0);
        add_byte(1'b0, 8'h33, CHK_PIXEL, one_px(8'h33, 8'h22, 8'h11, 1'b1, 1'b0));
        add_byte(1'b0, 8'h44, CHK_NONE, '0);   // past end of image
        add_byte(1'b1, 8'hC5, CHK_NONE, '0);
        add_byte(1'b0, 8'h7E, CHK_PIXEL, one_px(8'h7E, 8'h7E, 8'h7E, 1'b1, 1'b1));
        // zero width and zero stride: rows advance, nothing comes out
        add_geom(0, 1, 0);
        add_byte(1'b1, 8'h01, CHK_NONE, '0);
        add_byte(1'b0, 8'h02, CHK_NONE, '0);
        add_byte(1'b0, 8'h03, CHK_NONE, '0);
        add_byte(1'b0, 8'h04, CHK_NONE, '0);
        // zero height: stream closed from the start
        add_geom(4, 0, 4);
        add_byte(1'b1, 8'h55, CHK_NONE, '0);
        // 4x3, stride shrunk mid-row so the open row closes early;
        // width then exceeds stride
        add_geom(4, 3, 4);
        add_byte(1'b1, 8'hC8, CHK_MODEL, '0);
        add_byte(1'b0, 8'hA5, CHK_MODEL, '0);
        add_byte(1'b0, 8'h12, CHK_MODEL, '0);
        add_byte(1'b0, 8'h34, CHK_MODEL, '0);
        add_geom(4, 3, 2);
        add_byte(1'b0, 8'hFF, CHK_MODEL, '0);  // 63-byte run, clipped at row end
        add_byte(1'b0, 8'h5A, CHK_MODEL, '0);
        add_byte(1'b0, 8'hC4, CHK_MODEL, '0);
        add_byte(1'b0, 8'h80, CHK_MODEL, '0);
        add_byte(1'b0, 8'h7F, CHK_MODEL, '0);
        add_byte(1'b0, 8'hBF, CHK_MODEL, '0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            if (script[i].geom) begin
                settle();
                load_geometry(script[i].w, script[i].h, script[i].s);
            end else begin
                cur_chk = script[i].chk;
                cur_px  = script[i].px;
                push_byte(script[i].item);
            end
        end

        // random images on small geometries
        target = bytes_used + 180;
        while (bytes_used < target) begin
            r = $urandom_range(0, 9);
            s = (r == 0) ? 0 : $urandom_range(1, 8);
            r = $urandom_range(0, 7);
            if (r == 0)      w = 0;
            else if (r == 1) w = $urandom_range(((s == 0) ? 1 : s) + 1, 2048);
            else             w = $urandom_range(1, (s == 0) ? 1 : s);
            r = $urandom_range(0, 11);
            if (r == 0)      h = 0;
            else if (r == 1) h = 65536;
            else if (r == 2) h = $urandom_range(5, 65535);
            else             h = $urandom_range(1, 4);
            settle();
            idle_on = ($urandom_range(0, 3) != 0);
            load_geometry(w, h, s);
            random_image(1'b0, $urandom_range(8, 40));
        end

        // one full row at maximum width; stride above the store saturates
        settle();
        idle_on = ($urandom_range(0, 1) != 0);
        load_geometry(2048, 1, $urandom_range(2049, 4095));
        random_image(1'b1, 400);

        i_in_valid <= 1'b0;
        while (pending_px.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (fails == 0) begin
            $display("** pcx_rle_planar_to_rgb_decoder_unit: PASSED **");
        end else begin
            $display("** pcx_rle_planar_to_rgb_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
